>>> hw/rtl/dual_sorted_alarm_queue_top_macros.svh
// ---------------------------------------------------------------------------
// Dual sorted alarm queue assertion macros
// Shared concurrent assertion forms for the alarm queue RTL.
// ---------------------------------------------------------------------------
`ifndef DUAL_SORTED_ALARM_QUEUE_TOP_MACROS_SVH
`define DUAL_SORTED_ALARM_QUEUE_TOP_MACROS_SVH

// same-cycle implication
`define DSAQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DSAQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/dsaq_pkg.sv
// ---------------------------------------------------------------------------
// Dual sorted alarm queue package
// Constants, transfer payload types and queue control types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dsaq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_WIDTH   = 8;
  localparam int MAX_OUT     = 32;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int K_W   = $clog2(MAX_OUT);
  localparam logic [K_W-1:0] K_MAX = K_W'(MAX_OUT - 1);
  localparam logic [7:0] TAG_MASK =
    (TAG_WIDTH >= 8) ? 8'hFF : 8'((64'd1 << TAG_WIDTH) - 64'd1);

  typedef enum logic {
    FUNC_ADD  = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_EXPIRE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ADD   = 2'd1,
    ST_DRAIN = 2'd2
  } state_e;

  typedef enum logic [1:0] {
    Q_HOLD   = 2'd0,
    Q_INSERT = 2'd1,
    Q_POP    = 2'd2
  } q_op_e;

  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD_NEW  = 2'd1,
    CELL_FROM_PREV = 2'd2,
    CELL_FROM_NEXT = 2'd3
  } cell_op_e;

  typedef struct packed {
    func_e       func;
    logic [15:0] seconds;
    logic [7:0]  tag;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic        queue_id;
    logic [7:0]  rpt_tag;
    logic [31:0] expiry;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] expiry;
    logic [7:0]  tag;
  } entry_t;

  typedef struct packed {
    logic due;
    logic ins;
  } cell_flags_t;

  typedef struct packed {
    q_op_e       op;
    logic [31:0] key;
    logic [7:0]  tag;
  } q_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
    logic             head_due;
    logic             next_due;
    entry_t           head;
  } q_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/dsaq_cell.sv
// ---------------------------------------------------------------------------
// Alarm queue cell
// Holds one entry, compares it with the broadcast key and shifts to or
// from its neighbors.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsaq_cell (
  input  wire logic              clk_i,
  input  wire dsaq_pkg::cell_op_e op_i,
  input  wire logic [31:0]       key_i,
  input  wire dsaq_pkg::entry_t  prev_i,
  input  wire dsaq_pkg::entry_t  next_i,
  input  wire dsaq_pkg::entry_t  new_i,
  output dsaq_pkg::entry_t       entry_o,
  output dsaq_pkg::cell_flags_t  flags_o
);

  dsaq_pkg::entry_t entry_q, entry_d;
  logic [31:0]      diff;

  assign diff          = entry_q.expiry - key_i;
  assign flags_o.due   = (diff == 32'd0) || diff[31];
  assign flags_o.ins   = !diff[31] || (diff == 32'h8000_0000);
  assign entry_o       = entry_q;

  always_comb begin
    case (op_i)
      dsaq_pkg::CELL_LOAD_NEW:  entry_d = new_i;
      dsaq_pkg::CELL_FROM_PREV: entry_d = prev_i;
      dsaq_pkg::CELL_FROM_NEXT: entry_d = next_i;
      default:                  entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/dsaq_chain.sv
// ---------------------------------------------------------------------------
// Alarm queue chain
// One sorted queue as a row of cells with a fill count; insert in place,
// pop at the head.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsaq_chain (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dsaq_pkg::q_ctrl_t ctrl_i,
  output dsaq_pkg::q_stat_t     stat_o
);

  localparam int D = dsaq_pkg::QUEUE_DEPTH;

  logic [dsaq_pkg::CNT_W-1:0] count_q, count_d;
  dsaq_pkg::entry_t           new_e;
  dsaq_pkg::entry_t           entry [D];
  dsaq_pkg::entry_t           prev  [D];
  dsaq_pkg::entry_t           next  [D];
  dsaq_pkg::cell_flags_t      flags [D];
  dsaq_pkg::cell_op_e         cop   [D];
  logic [D-1:0]               vld;
  logic [D-1:0]               fit;
  logic [D-1:0]               shift;

  assign new_e.expiry = ctrl_i.key;
  assign new_e.tag    = ctrl_i.tag;
  assign shift[0]     = 1'b0;

  for (genvar i = 0; i < D; i++) begin : g_cell
    assign vld[i] = (dsaq_pkg::CNT_W'(i) < count_q);
    assign fit[i] = !vld[i] || flags[i].ins;

    if (i < D - 1) begin : g_carry
      assign shift[i+1] = shift[i] | fit[i];
      assign next[i]    = entry[i+1];
    end else begin : g_tail
      assign next[i]    = new_e;
    end

    if (i == 0) begin : g_head
      assign prev[i] = new_e;
    end else begin : g_body
      assign prev[i] = entry[i-1];
    end

    always_comb begin
      case (ctrl_i.op)
        dsaq_pkg::Q_INSERT: begin
          if (shift[i]) begin
            cop[i] = dsaq_pkg::CELL_FROM_PREV;
          end else if (fit[i]) begin
            cop[i] = dsaq_pkg::CELL_LOAD_NEW;
          end else begin
            cop[i] = dsaq_pkg::CELL_HOLD;
          end
        end
        dsaq_pkg::Q_POP: cop[i] = dsaq_pkg::CELL_FROM_NEXT;
        default:         cop[i] = dsaq_pkg::CELL_HOLD;
      endcase
    end

    dsaq_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cop[i]),
      .key_i   (ctrl_i.key),
      .prev_i  (prev[i]),
      .next_i  (next[i]),
      .new_i   (new_e),
      .entry_o (entry[i]),
      .flags_o (flags[i])
    );
  end

  always_comb begin
    case (ctrl_i.op)
      dsaq_pkg::Q_INSERT: count_d = count_q + dsaq_pkg::CNT_W'(1);
      dsaq_pkg::Q_POP:    count_d = count_q - dsaq_pkg::CNT_W'(1);
      default:            count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign stat_o.count    = count_q;
  assign stat_o.full     = (count_q == dsaq_pkg::CNT_W'(D));
  assign stat_o.head_due = vld[0] && flags[0].due;
  assign stat_o.next_due = vld[1] && flags[1].due;
  assign stat_o.head     = entry[0];

endmodule

`default_nettype wire

>>> hw/rtl/dual_sorted_alarm_queue_top.sv
// ---------------------------------------------------------------------------
// Dual sorted alarm queue
// Seconds counter with two expiry-sorted alarm queues built as cell chains.
// ---------------------------------------------------------------------------
//   channel | direction | payload    | carries
//   in      | input     | in_item_t  | add alarm or one-second tick
//   out     | output    | out_item_t | accepted, rejected or expired alarm
//
// An add takes the transfer and forms the expiry in IDLE; in ADD, with a free
//   output, it inserts in place across the cell row and registers the result.
// A tick steps the seconds count, then pops one expired alarm per transfer,
//   moves on to queue one when queue zero ends without a last transfer and
//   ends when queue one has nothing due; each cycle pops at most one head.
// Reset clears the seconds count and both fill counts; cell contents are
//   never read at or above the fill count.
// A stalled output holds the drain and the insert; the input is stalled
//   while any item is at work.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dual_sorted_alarm_queue_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire dsaq_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output dsaq_pkg::out_item_t      out_data_o
);

  `include "dual_sorted_alarm_queue_top_macros.svh"

  dsaq_pkg::state_e           state_q, state_d;
  logic [31:0]                now_q, now_d;
  logic [31:0]                add_exp_q, add_exp_d;
  logic [7:0]                 add_tag_q, add_tag_d;
  logic                       sel_q, sel_d;
  logic [dsaq_pkg::K_W-1:0]   k_q, k_d;
  logic                       out_vld_q, out_vld_d;
  dsaq_pkg::out_item_t        out_q, out_d;
  logic                       out_load;
  logic                       slot_free;
  logic                       in_acc;
  logic                       add_qid;
  logic                       add_full;
  logic                       drain_done;
  dsaq_pkg::q_ctrl_t          ctl0, ctl1;
  dsaq_pkg::q_stat_t          st0, st1;

  assign in_stall_o  = (state_q != dsaq_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_vld_q || !out_stall_i;
  assign add_qid     = !add_exp_q[0];
  assign add_full    = add_qid ? st1.full : st0.full;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  dsaq_chain u_chain0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctl0),
    .stat_o (st0)
  );

  dsaq_chain u_chain1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctl1),
    .stat_o (st1)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dsaq_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (in_data_i.func == dsaq_pkg::FUNC_ADD) ? dsaq_pkg::ST_ADD
                                                          : dsaq_pkg::ST_DRAIN;
        end
      end
      dsaq_pkg::ST_ADD: begin
        if (slot_free) begin
          state_d = dsaq_pkg::ST_IDLE;
        end
      end
      dsaq_pkg::ST_DRAIN: begin
        if (drain_done) begin
          state_d = dsaq_pkg::ST_IDLE;
        end
      end
      default: state_d = dsaq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    now_d      = now_q;
    add_exp_d  = add_exp_q;
    add_tag_d  = add_tag_q;
    sel_d      = sel_q;
    k_d        = k_q;
    out_load   = 1'b0;
    out_d      = out_q;
    drain_done = 1'b0;
    ctl0.op    = dsaq_pkg::Q_HOLD;
    ctl1.op    = dsaq_pkg::Q_HOLD;
    ctl0.key   = (state_q == dsaq_pkg::ST_DRAIN) ? now_q : add_exp_q;
    ctl1.key   = ctl0.key;
    ctl0.tag   = add_tag_q;
    ctl1.tag   = add_tag_q;
    unique case (state_q)
      dsaq_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.func == dsaq_pkg::FUNC_ADD) begin
            add_exp_d = now_q + {16'd0, in_data_i.seconds};
            add_tag_d = in_data_i.tag & dsaq_pkg::TAG_MASK;
          end else begin
            now_d = now_q + 32'd1;
            sel_d = 1'b0;
            k_d   = '0;
          end
        end
      end
      dsaq_pkg::ST_ADD: begin
        if (slot_free) begin
          out_load        = 1'b1;
          out_d.kind      = add_full ? dsaq_pkg::KIND_REJECT : dsaq_pkg::KIND_ACCEPT;
          out_d.queue_id  = add_qid;
          out_d.rpt_tag   = add_tag_q;
          out_d.expiry    = add_exp_q;
          out_d.last      = 1'b1;
          if (!add_full) begin
            if (add_qid) begin
              ctl1.op = dsaq_pkg::Q_INSERT;
            end else begin
              ctl0.op = dsaq_pkg::Q_INSERT;
            end
          end
        end
      end
      dsaq_pkg::ST_DRAIN: begin
        if (!sel_q) begin
          if (st0.head_due) begin
            if (slot_free) begin
              ctl0.op         = dsaq_pkg::Q_POP;
              out_load        = 1'b1;
              out_d.kind      = dsaq_pkg::KIND_EXPIRE;
              out_d.queue_id  = 1'b0;
              out_d.rpt_tag   = st0.head.tag;
              out_d.expiry    = st0.head.expiry;
              out_d.last      = (k_q == dsaq_pkg::K_MAX) ||
                                (!st0.next_due && !st1.head_due);
              k_d             = k_q + dsaq_pkg::K_W'(1);
              drain_done      = out_d.last;
            end
          end else begin
            sel_d = 1'b1;
          end
        end else begin
          if (st1.head_due) begin
            if (slot_free) begin
              ctl1.op         = dsaq_pkg::Q_POP;
              out_load        = 1'b1;
              out_d.kind      = dsaq_pkg::KIND_EXPIRE;
              out_d.queue_id  = 1'b1;
              out_d.rpt_tag   = st1.head.tag;
              out_d.expiry    = st1.head.expiry;
              out_d.last      = (k_q == dsaq_pkg::K_MAX) || !st1.next_due;
              k_d             = k_q + dsaq_pkg::K_W'(1);
              drain_done      = out_d.last;
            end
          end else begin
            drain_done = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_vld_d = out_load || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dsaq_pkg::ST_IDLE;
      now_q     <= '0;
      sel_q     <= 1'b0;
      k_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      now_q     <= now_d;
      sel_q     <= sel_d;
      k_q       <= k_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    add_exp_q <= add_exp_d;
    add_tag_q <= add_tag_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  `DSAQ_ASSERT_NEXT(a_reject_holds_q0, clk_i, rst_ni,
    state_q == dsaq_pkg::ST_ADD && slot_free && !add_qid && st0.full,
    $stable(st0.count), "full queue zero changed on a rejected add")
  `DSAQ_ASSERT_NEXT(a_pop_drops_one, clk_i, rst_ni,
    ctl0.op == dsaq_pkg::Q_POP,
    st0.count == $past(st0.count) - dsaq_pkg::CNT_W'(1), "pop did not drop one entry")
  `DSAQ_ASSERT_NOW(a_pop_only_due, clk_i, rst_ni,
    ctl1.op == dsaq_pkg::Q_POP, st1.head_due, "queue one popped an entry not yet due")
  `DSAQ_ASSERT_NEXT(a_last_ends_drain, clk_i, rst_ni,
    state_q == dsaq_pkg::ST_DRAIN && out_load && out_d.last,
    state_q == dsaq_pkg::ST_IDLE, "drain continued after its last transfer")

endmodule

`default_nettype wire
